// File: sv/somx_pkg.sv
// Shared types, constants and helpers for the servo output priority mixer.
// Used by somx_lane, somx_duty and servo_output_priority_mixer_unit.
// Depends on nothing else.
package somx_pkg;

  localparam int PULSE_W    = 16;
  localparam int VALUE_W    = 16;
  localparam int DUTY_W     = 15;
  localparam int MAX_CH     = 6;
  localparam int COUNT_W    = 3;
  localparam int KIND_W     = 2;
  localparam int OP_W       = 2;
  localparam int LEVEL_W    = 4;
  localparam int REM_W      = 13;
  localparam int MID_W      = 15;
  localparam int MASK_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int S_TDATA_W  = 112;
  localparam int M_TDATA_W  = 96;

  localparam int COUNT_LSB  = MAX_CH * VALUE_W;
  localparam int KIND_LSB   = COUNT_LSB + COUNT_W;
  localparam int ESTOP_BIT  = KIND_LSB + KIND_W;
  localparam int GEST_BIT   = ESTOP_BIT + 1;
  localparam int MASK_LSB   = GEST_BIT + 1;

  localparam int EXP_BIT    = MAX_CH * DUTY_W;
  localparam int TMR_BIT    = EXP_BIT + 1;

  localparam logic [PULSE_W-1:0] BASE_US        = 16'd1500;
  localparam logic [PULSE_W-1:0] LEVEL_STEP_US  = 16'd50;
  localparam logic [REM_W-1:0]   STROKE_UNIT_MS = 13'd500;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN      = 4'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 4'd10;

  localparam logic [LEVEL_W-1:0]    RST_FORCE  = 4'd10;
  localparam logic [LEVEL_W-1:0]    RST_STROKE = 4'd8;
  localparam logic [VALUE_W-1:0]    RST_THRESH = 16'd650;
  localparam logic [MID_W-1:0]      RST_MID    = 15'd1500;
  localparam logic [MID_W-1:0]      RST_AUX_HI = 15'd1800;
  localparam logic [MID_W-1:0]      RST_AUX_LO = 15'd1350;

  localparam logic [KIND_W-1:0] KIND_TIMED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REST  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_FRAME = 2'd0,
    OP_POSE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CTRL  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE  = 3'd0,
    CFG_STROKE = 3'd1,
    CFG_THRESH = 3'd2,
    CFG_MID    = 3'd3,
    CFG_AUX_HI = 3'd4,
    CFG_AUX_LO = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  typedef struct packed {
    op_t  op;
    logic stop;
    logic gest;
    logic gest_enter;
    logic expire;
    logic frame_full;
    logic frame_any;
    logic sense_hi;
  } lane_ctl_t;

  typedef struct packed {
    logic [PULSE_W-1:0] mid;
    logic [PULSE_W-1:0] hi;
    logic [PULSE_W-1:0] lo;
    logic [PULSE_W-1:0] aux_hi;
    logic [PULSE_W-1:0] aux_lo;
    logic [VALUE_W-1:0] thresh;
  } lane_lvl_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    logic [LEVEL_W-1:0] r;
    r = v;
    if (v < LEVEL_MIN) r = LEVEL_MIN;
    if (v > LEVEL_MAX) r = LEVEL_MAX;
    return r;
  endfunction

endpackage

// File: sv/somx_lane.sv
// One channel lane of the servo output mixer: next pulse and pose for a word.
// Depends on somx_pkg for the lane control and level structs.
module somx_lane (
  input  somx_pkg::lane_ctl_t           ctl,
  input  somx_pkg::lane_lvl_t           lvl,
  input  logic                          is_direct,
  input  logic                          take,
  input  logic                          ovr,
  input  logic [somx_pkg::VALUE_W-1:0]  val,
  input  logic [somx_pkg::PULSE_W-1:0]  last,
  input  logic [somx_pkg::PULSE_W-1:0]  pose,
  output logic [somx_pkg::PULSE_W-1:0]  last_next,
  output logic [somx_pkg::PULSE_W-1:0]  pose_next,
  output logic                          changed,
  output logic                          exp_changed
);
  import somx_pkg::*;

  logic [PULSE_W-1:0] pose_upd;
  logic [PULSE_W-1:0] exp_pose;

  always_comb begin
    pose_upd    = take ? val : pose;
    changed     = take && (pose != val);
    exp_pose    = is_direct ? lvl.mid : pose;
    exp_changed = is_direct && (pose != lvl.mid);
    last_next   = last;
    pose_next   = pose;
    case (ctl.op)
      OP_FRAME: begin
        if (ctl.stop) begin
          last_next = lvl.mid;
        end else if (ctl.gest) begin
          last_next = pose;
        end else if (ovr) begin
          last_next = lvl.mid;
        end else if (is_direct) begin
          if (ctl.frame_full) begin
            if ($signed(val) < $signed(lvl.thresh)) begin
              last_next = lvl.hi;
            end else if ($signed(val) > $signed(lvl.thresh)) begin
              last_next = lvl.lo;
            end else begin
              last_next = lvl.mid;
            end
          end
        end else if (ctl.frame_any) begin
          last_next = ctl.sense_hi ? lvl.aux_hi : lvl.aux_lo;
        end
      end
      OP_POSE: begin
        pose_next = pose_upd;
        last_next = ctl.stop ? lvl.mid : pose_upd;
      end
      OP_TICK: begin
        if (ctl.expire) begin
          pose_next = exp_pose;
          last_next = exp_pose;
        end
      end
      OP_CTRL: begin
        if (ctl.gest_enter) pose_next = last;
      end
      default: begin
        last_next = last;
      end
    endcase
  end

endmodule

// File: sv/somx_duty.sv
// Pipelined pulse-to-duty conversion for one channel, four register stages.
// Divides by the period through a reciprocal multiply and one correction.
// Depends on somx_pkg for widths and the stage enable struct.
module somx_duty #(
  parameter int DUTY_BITS = 14,
  parameter int PERIOD_US = 20000
) (
  input  logic                          clk,
  input  somx_pkg::pipe_en_t            en,
  input  logic [somx_pkg::PULSE_W-1:0]  pulse,
  output logic [somx_pkg::DUTY_W-1:0]   duty
);
  import somx_pkg::*;

  localparam int QW = DUTY_BITS + 1;
  localparam int KW = DUTY_BITS + PULSE_W + 1 - $clog2(PERIOD_US);
  localparam logic [63:0] K_FULL = (64'd1 << (DUTY_BITS + PULSE_W)) / 64'(PERIOD_US);
  localparam logic [KW-1:0] RECIP = KW'(K_FULL);
  localparam logic [PULSE_W-1:0] PERIOD = PULSE_W'(PERIOD_US);

  logic [PULSE_W-1:0]           s1_pulse;
  logic [PULSE_W-1:0]           u_clamp;
  logic [PULSE_W+KW-1:0]        prod;
  logic [PULSE_W-1:0]           s2_u;
  logic [QW-1:0]                s2_q;
  logic [PULSE_W-1:0]           s3_u;
  logic [QW-1:0]                s3_q;
  logic [QW+PULSE_W-1:0]        s3_lim;
  logic [QW+PULSE_W-1:0]        num;
  logic [QW-1:0]                q_fix;

  always_comb begin
    u_clamp = (s1_pulse > PERIOD) ? PERIOD : s1_pulse;
    prod    = (PULSE_W+KW)'(u_clamp) * (PULSE_W+KW)'(RECIP);
    num     = (QW+PULSE_W)'({s3_u, {DUTY_BITS{1'b0}}});
    q_fix   = (num >= s3_lim) ? (s3_q + QW'(1)) : s3_q;
  end

  always_ff @(posedge clk) begin
    if (en.s1) s1_pulse <= pulse;
    if (en.s2) begin
      s2_u <= u_clamp;
      s2_q <= prod[PULSE_W +: QW];
    end
    if (en.s3) begin
      s3_u   <= s2_u;
      s3_q   <= s2_q;
      s3_lim <= (QW+PULSE_W)'(s2_q + QW'(1)) * (QW+PULSE_W)'(PERIOD);
    end
    if (en.s4) duty <= DUTY_W'(q_fix);
  end

endmodule

// File: sv/servo_output_priority_mixer_unit.sv
// Top level of the servo output priority mixer: state, timer, lanes, merge.
// Depends on somx_pkg, somx_lane and somx_duty.
//
// Usage: each input word on the s_axis channel is one operation, chosen by
// s_axis_tuser: a sensor frame, a gesture pose, a millisecond tick or a
// control write. Every accepted word yields exactly one result word on the
// m_axis channel holding the duty of every channel plus the expiry and timer
// flags. Channel state is updated in the cycle the word is accepted, one
// lane per channel evaluating the priority chain side by side.
// The result is valid once the word has passed the four-stage duty pipeline
// that each channel carries (input register, reciprocal multiply, limit
// product, correction), whose first stage loads on acceptance. One word is
// accepted per cycle while the pipeline is not stalled by the receiver.
// The configuration registers are written through cfg_we, cfg_index and
// cfg_data and take effect on the next accepted word.
// Reset restores all channels to a 1500 us pulse, clears the pose, timer and
// flags, loads the register defaults and empties the pipeline.
// When the receiver stalls, results stay in the pipeline registers and the
// input keeps accepting words until all stages hold a result.
module servo_output_priority_mixer_unit #(
  parameter int CHANNELS        = 6,
  parameter int DIRECT_CHANNELS = 5,
  parameter int DUTY_BITS       = 14,
  parameter int PERIOD_US       = 20000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // value_0..value_5, count, gesture_kind, estop_on, gesture_on, override_mask
  input  logic [somx_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // op
  input  logic [somx_pkg::OP_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // duty_0..duty_5, expired, timer_running
  output logic [somx_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [somx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [somx_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import somx_pkg::*;

  logic [LEVEL_W-1:0] force_level;
  logic [LEVEL_W-1:0] stroke_level;
  logic [VALUE_W-1:0] center_threshold;
  logic [MID_W-1:0]   mid_pulse_us;
  logic [MID_W-1:0]   aux_high_us;
  logic [MID_W-1:0]   aux_low_us;

  logic [PULSE_W-1:0] last_pulse [CHANNELS];
  logic [PULSE_W-1:0] pose_pulse [CHANNELS];
  logic [PULSE_W-1:0] last_nx    [CHANNELS];
  logic [PULSE_W-1:0] pose_nx    [CHANNELS];
  logic [PULSE_W-1:0] duty_in    [CHANNELS];
  logic [DUTY_W-1:0]  duty_out   [CHANNELS];
  logic [CHANNELS-1:0] chg;
  logic [CHANNELS-1:0] exp_chg;

  logic               timer_active;
  logic [REM_W-1:0]   remaining_ms;
  logic               stop_flag;
  logic               gesture_flag;
  logic [MASK_W-1:0]  override_bits;

  logic               timer_next;
  logic [REM_W-1:0]   remaining_next;

  logic [VALUE_W-1:0] vals [MAX_CH];
  op_t                op_in;
  logic [COUNT_W-1:0] count_in;
  logic [KIND_W-1:0]  kind_in;
  logic               estop_in;
  logic               gest_in;
  logic [MASK_W-1:0]  mask_in;

  lane_ctl_t          ctl;
  lane_lvl_t          lvl;
  logic [REM_W-1:0]   stroke_ms;
  logic [REM_W-1:0]   rem_dec;
  logic               accept;
  logic               restart;

  logic               v1, v2, v3, v4;
  logic               ready1, ready2, ready3, ready4;
  pipe_en_t           en;
  logic [1:0]         f1, f2, f3, f4;

  always_comb begin
    for (int k = 0; k < MAX_CH; k++) vals[k] = s_axis_tdata[k*VALUE_W +: VALUE_W];
    op_in    = op_t'(s_axis_tuser);
    count_in = s_axis_tdata[COUNT_LSB +: COUNT_W];
    kind_in  = s_axis_tdata[KIND_LSB +: KIND_W];
    estop_in = s_axis_tdata[ESTOP_BIT];
    gest_in  = s_axis_tdata[GEST_BIT];
    mask_in  = s_axis_tdata[MASK_LSB +: MASK_W];
  end

  // Pipeline handshake: a stage loads when it is empty or the next one moves.
  always_comb begin
    ready4 = !v4 || m_axis_tready;
    ready3 = !v3 || ready4;
    ready2 = !v2 || ready3;
    ready1 = !v1 || ready2;
    en     = '{s1: ready1, s2: ready2, s3: ready3, s4: ready4};
    s_axis_tready = ready1;
    accept = s_axis_tvalid && ready1;
  end

  always_comb begin
    stroke_ms  = (REM_W'(stroke_level) + REM_W'(1)) * STROKE_UNIT_MS;
    rem_dec    = (remaining_ms != '0) ? (remaining_ms - REM_W'(1)) : remaining_ms;
    lvl.mid    = PULSE_W'(mid_pulse_us);
    lvl.hi     = BASE_US + PULSE_W'(force_level) * LEVEL_STEP_US;
    lvl.lo     = BASE_US - PULSE_W'(force_level) * LEVEL_STEP_US;
    lvl.aux_hi = PULSE_W'(aux_high_us);
    lvl.aux_lo = PULSE_W'(aux_low_us);
    lvl.thresh = center_threshold;
    ctl.op         = op_in;
    ctl.stop       = stop_flag;
    ctl.gest       = gesture_flag;
    ctl.gest_enter = gest_in && !gesture_flag;
    ctl.expire     = (op_in == OP_TICK) && timer_active && !stop_flag && gesture_flag
                     && (rem_dec == '0);
    ctl.frame_full = count_in >= COUNT_W'(DIRECT_CHANNELS);
    ctl.frame_any  = count_in != '0;
    ctl.sense_hi   = $signed(vals[0]) > $signed(center_threshold);
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    somx_lane u_lane (
      .ctl         (ctl),
      .lvl         (lvl),
      .is_direct   (i < DIRECT_CHANNELS),
      .take        (count_in > COUNT_W'(i)),
      .ovr         (override_bits[i]),
      .val         (vals[i]),
      .last        (last_pulse[i]),
      .pose        (pose_pulse[i]),
      .last_next   (last_nx[i]),
      .pose_next   (pose_nx[i]),
      .changed     (chg[i]),
      .exp_changed (exp_chg[i])
    );

    assign duty_in[i] = accept ? last_nx[i] : last_pulse[i];

    somx_duty #(
      .DUTY_BITS (DUTY_BITS),
      .PERIOD_US (PERIOD_US)
    ) u_duty (
      .clk   (clk),
      .en    (en),
      .pulse (duty_in[i]),
      .duty  (duty_out[i])
    );
  end

  always_comb begin
    restart        = (|chg) && gesture_flag && !stop_flag;
    timer_next     = timer_active;
    remaining_next = remaining_ms;
    case (op_in)
      OP_POSE: begin
        if ((kind_in == KIND_TIMED) || restart) remaining_next = stroke_ms;
        timer_next = (kind_in == KIND_TIMED) || ((kind_in != KIND_REST) && restart);
      end
      OP_TICK: begin
        if (timer_active) begin
          if (stop_flag || !gesture_flag) begin
            timer_next = 1'b0;
          end else if (ctl.expire) begin
            remaining_next = (|exp_chg) ? stroke_ms : '0;
            timer_next     = 1'b0;
          end else begin
            remaining_next = rem_dec;
          end
        end
      end
      default: begin
        timer_next = timer_active;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        last_pulse[k] <= BASE_US;
        pose_pulse[k] <= '0;
      end
      timer_active  <= 1'b0;
      remaining_ms  <= '0;
      stop_flag     <= 1'b0;
      gesture_flag  <= 1'b0;
      override_bits <= '0;
    end else if (accept) begin
      for (int k = 0; k < CHANNELS; k++) begin
        last_pulse[k] <= last_nx[k];
        pose_pulse[k] <= pose_nx[k];
      end
      timer_active <= timer_next;
      remaining_ms <= remaining_next;
      if (op_in == OP_CTRL) begin
        stop_flag     <= estop_in;
        gesture_flag  <= gest_in;
        override_bits <= mask_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      force_level      <= RST_FORCE;
      stroke_level     <= RST_STROKE;
      center_threshold <= RST_THRESH;
      mid_pulse_us     <= RST_MID;
      aux_high_us      <= RST_AUX_HI;
      aux_low_us       <= RST_AUX_LO;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FORCE:  force_level      <= clamp_level(cfg_data[LEVEL_W-1:0]);
        CFG_STROKE: stroke_level     <= clamp_level(cfg_data[LEVEL_W-1:0]);
        CFG_THRESH: center_threshold <= cfg_data[VALUE_W-1:0];
        CFG_MID:    mid_pulse_us     <= cfg_data[MID_W-1:0];
        CFG_AUX_HI: aux_high_us      <= cfg_data[MID_W-1:0];
        CFG_AUX_LO: aux_low_us       <= cfg_data[MID_W-1:0];
        default:    force_level      <= force_level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= s_axis_tvalid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) f1 <= accept ? {timer_next, ctl.expire} : {timer_active, 1'b0};
    if (ready2) f2 <= f1;
    if (ready3) f3 <= f2;
    if (ready4) f4 <= f3;
  end

  // Merge the lane results into the outgoing word.
  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < CHANNELS; k++) m_axis_tdata[k*DUTY_W +: DUTY_W] = duty_out[k];
    m_axis_tdata[EXP_BIT] = f4[0];
    m_axis_tdata[TMR_BIT] = f4[1];
    m_axis_tvalid = v4;
  end

  ap_timer_count: assert property (@(posedge clk) disable iff (rst)
    timer_active |-> (remaining_ms != '0))
    else $error("timer running with zero remaining time");

  ap_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[EXP_BIT] && m_axis_tdata[TMR_BIT]))
    else $error("expired word reports a running timer");

  ap_stop_set: assert property (@(posedge clk) disable iff (rst)
    (accept && (op_in == OP_CTRL) && estop_in) |=> stop_flag)
    else $error("stop control word did not set the stop flag");

endmodule
